// File: sv/mmcsr_pkg.sv
// ----------------------------------------------------------------------------
// Machine-mode CSR file package
// Types, CSR addresses, field masks and instruction codes shared by the
// machine-mode CSR file modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmcsr_pkg;

	localparam logic [11:0] CSR_ADDR_MSTATUS   = 12'h300;
	localparam logic [11:0] CSR_ADDR_MISA      = 12'h301;
	localparam logic [11:0] CSR_ADDR_MIE       = 12'h304;
	localparam logic [11:0] CSR_ADDR_MTVEC     = 12'h305;
	localparam logic [11:0] CSR_ADDR_MEPC      = 12'h341;
	localparam logic [11:0] CSR_ADDR_MCAUSE    = 12'h342;
	localparam logic [11:0] CSR_ADDR_MTVAL     = 12'h343;
	localparam logic [11:0] CSR_ADDR_MIP       = 12'h344;
	localparam logic [11:0] CSR_ADDR_MVENDORID = 12'hF11;
	localparam logic [11:0] CSR_ADDR_MARCHID   = 12'hF12;
	localparam logic [11:0] CSR_ADDR_MIMPID    = 12'hF13;
	localparam logic [11:0] CSR_ADDR_MHARTID   = 12'hF14;

	localparam logic [31:0] CSR_STATUS_MASK     = 32'h807F_F9BB;
	localparam logic [1:0]  CSR_MPP_RESERVED    = 2'b10;
	localparam logic [11:0] CSR_IRQ_MASK        = 12'hBBB;
	localparam logic [31:0] CSR_MTVEC_BASE_MASK = 32'hFFFF_FFFC;
	localparam logic [31:0] CSR_MTVEC_MODE_MASK = 32'h0000_0003;

	localparam logic [2:0] OP_RW  = 3'd0;
	localparam logic [2:0] OP_RS  = 3'd1;
	localparam logic [2:0] OP_RC  = 3'd2;
	localparam logic [2:0] OP_RWI = 3'd3;
	localparam logic [2:0] OP_RSI = 3'd4;
	localparam logic [2:0] OP_RCI = 3'd5;

	localparam logic [2:0] CFG_ISA_WORD  = 3'd0;
	localparam logic [2:0] CFG_VENDOR_ID = 3'd1;
	localparam logic [2:0] CFG_ARCH_ID   = 3'd2;
	localparam logic [2:0] CFG_IMPL_ID   = 3'd3;
	localparam logic [2:0] CFG_HART_ID   = 3'd4;

	localparam logic [31:0] ISA_WORD_RESET = 32'h4000_0000;

	typedef struct packed {
		logic [31:0] isa_word;
		logic [31:0] vendor_id;
		logic [31:0] arch_id;
		logic [31:0] impl_id;
		logic [31:0] hart_id;
	} cfg_t;

	typedef struct packed {
		logic [31:0] status_bits;
		logic [29:0] trap_base;
		logic        trap_vectored;
		logic [11:0] pending_bits;
		logic [11:0] enable_bits;
		logic [31:0] trap_cause;
		logic [31:0] exception_pc;
		logic [31:0] trap_value;
	} csr_state_t;

	typedef struct packed {
		logic        wen;
		logic [11:0] index;
		logic [31:0] data;
	} csr_wr_t;

endpackage

// File: sv/mmcsr_cfg_regs.sv
// ----------------------------------------------------------------------------
// Machine-mode CSR file configuration registers
// Holds the read-only identification values written through the
// configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmcsr_cfg_regs import mmcsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.isa_word  <= ISA_WORD_RESET;
			cfg_q.vendor_id <= '0;
			cfg_q.arch_id   <= '0;
			cfg_q.impl_id   <= '0;
			cfg_q.hart_id   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ISA_WORD:  cfg_q.isa_word  <= wr_data;
				CFG_VENDOR_ID: cfg_q.vendor_id <= wr_data;
				CFG_ARCH_ID:   cfg_q.arch_id   <= wr_data;
				CFG_IMPL_ID:   cfg_q.impl_id   <= wr_data;
				CFG_HART_ID:   cfg_q.hart_id   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/mmcsr_exec.sv
// ----------------------------------------------------------------------------
// Machine-mode CSR file execute logic
// Reads the addressed CSR, flags unsupported indexes and codes, and builds
// the write command for the read-write, read-set and read-clear forms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmcsr_exec import mmcsr_pkg::*; (
	input  logic        fire,
	input  logic [2:0]  op,
	input  logic [11:0] csr_index,
	input  logic [31:0] source_value,
	input  logic        source_is_x0,
	input  cfg_t        cfg,
	input  csr_state_t  state,
	output logic [31:0] old_value,
	output logic        illegal,
	output csr_wr_t     wr
);

	logic [31:0] rd_val;
	logic        known;
	logic [31:0] src;
	logic [31:0] new_val;
	logic        do_write;

	always_comb begin
		known  = 1'b1;
		rd_val = '0;
		unique case (csr_index)
			CSR_ADDR_MISA:      rd_val = cfg.isa_word;
			CSR_ADDR_MVENDORID: rd_val = cfg.vendor_id;
			CSR_ADDR_MARCHID:   rd_val = cfg.arch_id;
			CSR_ADDR_MIMPID:    rd_val = cfg.impl_id;
			CSR_ADDR_MHARTID:   rd_val = cfg.hart_id;
			CSR_ADDR_MSTATUS:   rd_val = state.status_bits;
			CSR_ADDR_MTVEC:     rd_val = {state.trap_base, 1'b0, state.trap_vectored};
			CSR_ADDR_MIP:       rd_val = {20'd0, state.pending_bits};
			CSR_ADDR_MIE:       rd_val = {20'd0, state.enable_bits};
			CSR_ADDR_MCAUSE:    rd_val = state.trap_cause;
			CSR_ADDR_MEPC:      rd_val = state.exception_pc;
			CSR_ADDR_MTVAL:     rd_val = state.trap_value;
			default:            known  = 1'b0;
		endcase
	end

	always_comb begin
		src      = source_value;
		new_val  = source_value;
		do_write = 1'b0;
		unique case (op)
			OP_RW: begin
				do_write = 1'b1;
			end
			OP_RS: begin
				new_val  = rd_val | src;
				do_write = !source_is_x0;
			end
			OP_RC: begin
				new_val  = rd_val & ~src;
				do_write = !source_is_x0;
			end
			OP_RWI: begin
				src      = {27'd0, source_value[4:0]};
				new_val  = src;
				do_write = 1'b1;
			end
			OP_RSI: begin
				src      = {27'd0, source_value[4:0]};
				new_val  = rd_val | src;
				do_write = (source_value[4:0] != 5'd0);
			end
			OP_RCI: begin
				src      = {27'd0, source_value[4:0]};
				new_val  = rd_val & ~src;
				do_write = (source_value[4:0] != 5'd0);
			end
			default: begin
				do_write = 1'b0;
			end
		endcase
	end

	assign illegal   = !known || (op > OP_RCI);
	assign old_value = illegal ? 32'd0 : rd_val;

	assign wr.wen   = fire && !illegal && do_write;
	assign wr.index = csr_index;
	assign wr.data  = new_val;

endmodule

// File: sv/mmcsr_state.sv
// ----------------------------------------------------------------------------
// Machine-mode CSR file state registers
// Stores the writable CSRs and keeps only their architected bits, holding
// the previous MPP and trap mode when a reserved value is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmcsr_state import mmcsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  csr_wr_t    wr,
	output csr_state_t state
);

	csr_state_t state_q;
	csr_state_t state_d;
	logic [31:0] status_nv;
	logic [31:0] tvec_base;
	logic [31:0] tvec_mode;

	always_comb begin
		state_d   = state_q;
		status_nv = wr.data & CSR_STATUS_MASK;
		tvec_base = wr.data & CSR_MTVEC_BASE_MASK;
		tvec_mode = wr.data & CSR_MTVEC_MODE_MASK;
		if (status_nv[12:11] == CSR_MPP_RESERVED) begin
			status_nv[12:11] = state_q.status_bits[12:11];
		end
		if (wr.wen) begin
			unique case (wr.index)
				CSR_ADDR_MSTATUS: state_d.status_bits = status_nv;
				CSR_ADDR_MTVEC: begin
					state_d.trap_base = tvec_base[31:2];
					if (!tvec_mode[1]) begin
						state_d.trap_vectored = tvec_mode[0];
					end
				end
				CSR_ADDR_MIP:    state_d.pending_bits = wr.data[11:0] & CSR_IRQ_MASK;
				CSR_ADDR_MIE:    state_d.enable_bits  = wr.data[11:0] & CSR_IRQ_MASK;
				CSR_ADDR_MCAUSE: state_d.trap_cause   = wr.data;
				CSR_ADDR_MEPC:   state_d.exception_pc = wr.data;
				CSR_ADDR_MTVAL:  state_d.trap_value   = wr.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

endmodule

// File: sv/machine_mode_csr_file_top.sv
// ----------------------------------------------------------------------------
// Machine-mode CSR file, top level
// Executes one RV32 Zicsr instruction per word against the machine-mode CSR
// file and returns the old CSR value, or flags an unsupported index or code.
// The block accepts one word per cycle while the output side is not stalled.
// A word is captured in an input register; the CSR read-modify-write then
// runs between that register and the result register when the latter is
// free or being read, and the next word sees the updated state. The result
// register lets a new word enter while a finished result is still waiting.
// The identification registers are written through the configuration port,
// which is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module machine_mode_csr_file_top import mmcsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [11:0] csr_index,
	input  logic [31:0] source_value,
	input  logic        source_is_x0,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] old_value,
	output logic        illegal,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [11:0] csr_index_s1;
	logic [31:0] source_value_s1;
	logic        source_is_x0_s1;
	logic        valid_s2;
	logic [31:0] old_value_s2;
	logic        illegal_s2;

	logic        advance;
	logic        in_take;
	cfg_t        cfg;
	csr_state_t  state;
	csr_wr_t     wr;
	logic [31:0] exec_old;
	logic        exec_illegal;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign cfg_ready = 1'b1;

	mmcsr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	mmcsr_exec u_exec (
		.fire         (advance),
		.op           (op_s1),
		.csr_index    (csr_index_s1),
		.source_value (source_value_s1),
		.source_is_x0 (source_is_x0_s1),
		.cfg          (cfg),
		.state        (state),
		.old_value    (exec_old),
		.illegal      (exec_illegal),
		.wr           (wr)
	);

	mmcsr_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.state  (state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1           <= op;
			csr_index_s1    <= csr_index;
			source_value_s1 <= source_value;
			source_is_x0_s1 <= source_is_x0;
		end
		if (advance) begin
			old_value_s2 <= exec_old;
			illegal_s2   <= exec_illegal;
		end
	end

	assign out_valid = valid_s2;
	assign old_value = old_value_s2;
	assign illegal   = illegal_s2;

	a_illegal_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal |-> old_value == 32'd0)
		else $error("illegal result carries a non-zero old value");

	a_status_masked: assert property (@(posedge clk) disable iff (!arst_n)
		((state.status_bits & ~CSR_STATUS_MASK) == 32'd0)
		&& (state.status_bits[12:11] != CSR_MPP_RESERVED))
		else $error("mstatus holds unarchitected bits or a reserved MPP");

	a_irq_masked: assert property (@(posedge clk) disable iff (!arst_n)
		((state.pending_bits & ~CSR_IRQ_MASK) == 12'd0)
		&& ((state.enable_bits & ~CSR_IRQ_MASK) == 12'd0))
		else $error("mip or mie holds unarchitected bits");

	a_no_write_when_illegal: assert property (@(posedge clk) disable iff (!arst_n)
		exec_illegal || !advance |=> $stable(state))
		else $error("CSR state changed without a legal instruction");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Machine-mode CSR file testbench
// Drives Zicsr instructions through the CSR file and checks every returned
// old value and illegal flag against a behavioural copy of the CSR state.
// The identification registers are reprogrammed between phases. The phases
// vary sender gaps and receiver stalls, and one of them holds the receiver
// off long enough for the block to fill up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import mmcsr_pkg::*;;

	localparam logic [2:0]  OP_UNDEF_LO     = 3'd6;
	localparam logic [2:0]  OP_UNDEF_HI     = 3'd7;
	localparam logic [11:0] UNKNOWN_CSR_LO  = 12'h000;
	localparam logic [11:0] UNKNOWN_CSR_HI  = 12'hFFF;
	localparam int          STUCK_LIMIT     = 2000;
	localparam int          HOLD_CYCLES     = 60;
	localparam int          SETTLE_CYCLES   = 10;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] idx;
		logic [31:0] src;
		logic        x0;
	} csr_instr_t;

	typedef struct packed {
		logic [31:0] old_value;
		logic        illegal;
	} csr_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = '0;
	logic [11:0] csr_index = '0;
	logic [31:0] source_value = '0;
	logic        source_is_x0 = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] old_value;
	logic        illegal;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Predicted identification values and CSR state.
	logic [31:0] isa_q = ISA_WORD_RESET;
	logic [31:0] vendor_q = '0;
	logic [31:0] arch_q = '0;
	logic [31:0] impl_q = '0;
	logic [31:0] hart_q = '0;
	logic [31:0] mstatus_q = '0;
	logic [29:0] mtvec_base_q = '0;
	logic        mtvec_mode_q = 1'b0;
	logic [11:0] mip_q = '0;
	logic [11:0] mie_q = '0;
	logic [31:0] mcause_q = '0;
	logic [31:0] mepc_q = '0;
	logic [31:0] mtval_q = '0;

	csr_instr_t  instr_q[$];
	csr_result_t csr_reads_q[$];
	csr_instr_t  drv_word;
	csr_result_t seen;
	csr_result_t want;

	logic in_taken = 1'b0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	int   holds_asked = 0;
	int   holds_done = 0;
	int   hold_left = 0;
	int   items_queued = 0;
	int   results_seen = 0;
	int   stuck_cycles = 0;
	int   errors = 0;

	machine_mode_csr_file_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.csr_index    (csr_index),
		.source_value (source_value),
		.source_is_x0 (source_is_x0),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.old_value    (old_value),
		.illegal      (illegal),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic csr_result_t exec_csr_instr(csr_instr_t w);
		csr_result_t r;
		logic        known;
		logic        do_write;
		logic [31:0] src;
		logic [31:0] nv;
		known = 1'b1;
		do_write = 1'b0;
		nv = '0;
		case (w.idx)
			CSR_ADDR_MISA:      r.old_value = isa_q;
			CSR_ADDR_MVENDORID: r.old_value = vendor_q;
			CSR_ADDR_MARCHID:   r.old_value = arch_q;
			CSR_ADDR_MIMPID:    r.old_value = impl_q;
			CSR_ADDR_MHARTID:   r.old_value = hart_q;
			CSR_ADDR_MSTATUS:   r.old_value = mstatus_q;
			CSR_ADDR_MTVEC:     r.old_value = {mtvec_base_q, 1'b0, mtvec_mode_q};
			CSR_ADDR_MIP:       r.old_value = {20'd0, mip_q};
			CSR_ADDR_MIE:       r.old_value = {20'd0, mie_q};
			CSR_ADDR_MCAUSE:    r.old_value = mcause_q;
			CSR_ADDR_MEPC:      r.old_value = mepc_q;
			CSR_ADDR_MTVAL:     r.old_value = mtval_q;
			default: begin
				r.old_value = '0;
				known = 1'b0;
			end
		endcase
		r.illegal = !known || (w.op > OP_RCI);
		if (r.illegal) begin
			r.old_value = '0;
			return r;
		end
		src = (w.op >= OP_RWI) ? {27'd0, w.src[4:0]} : w.src;
		case (w.op)
			OP_RW, OP_RWI: begin
				nv = src;
				do_write = 1'b1;
			end
			OP_RS: begin
				nv = r.old_value | src;
				do_write = !w.x0;
			end
			OP_RC: begin
				nv = r.old_value & ~src;
				do_write = !w.x0;
			end
			OP_RSI: begin
				nv = r.old_value | src;
				do_write = (src != '0);
			end
			default: begin
				nv = r.old_value & ~src;
				do_write = (src != '0);
			end
		endcase
		if (do_write) begin
			case (w.idx)
				CSR_ADDR_MSTATUS: begin
					nv = nv & CSR_STATUS_MASK;
					if (nv[12:11] == CSR_MPP_RESERVED)
						nv[12:11] = mstatus_q[12:11];
					mstatus_q = nv;
				end
				CSR_ADDR_MTVEC: begin
					mtvec_base_q = 30'((nv & CSR_MTVEC_BASE_MASK) >> 2);
					if ((nv & CSR_MTVEC_MODE_MASK) < 32'd2)
						mtvec_mode_q = nv[0];
				end
				CSR_ADDR_MIP:    mip_q = nv[11:0] & CSR_IRQ_MASK;
				CSR_ADDR_MIE:    mie_q = nv[11:0] & CSR_IRQ_MASK;
				CSR_ADDR_MCAUSE: mcause_q = nv;
				CSR_ADDR_MEPC:   mepc_q = nv;
				CSR_ADDR_MTVAL:  mtval_q = nv;
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic csr_instr_t rand_instr();
		csr_instr_t w;
		if ($urandom_range(99) < 88) begin
			case ($urandom_range(11))
				0:  w.idx = CSR_ADDR_MSTATUS;
				1:  w.idx = CSR_ADDR_MISA;
				2:  w.idx = CSR_ADDR_MIE;
				3:  w.idx = CSR_ADDR_MTVEC;
				4:  w.idx = CSR_ADDR_MEPC;
				5:  w.idx = CSR_ADDR_MCAUSE;
				6:  w.idx = CSR_ADDR_MTVAL;
				7:  w.idx = CSR_ADDR_MIP;
				8:  w.idx = CSR_ADDR_MVENDORID;
				9:  w.idx = CSR_ADDR_MARCHID;
				10: w.idx = CSR_ADDR_MIMPID;
				default: w.idx = CSR_ADDR_MHARTID;
			endcase
		end else begin
			w.idx = 12'($urandom_range(4095));
		end
		if ($urandom_range(99) < 6)
			w.op = 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
		else
			w.op = 3'($urandom_range(OP_RCI));
		case ($urandom_range(3))
			0: w.src = '0;
			1: w.src = '1;
			2: w.src = $urandom;
			default: w.src = $urandom_range(31);
		endcase
		w.x0 = ($urandom_range(3) == 0);
		return w;
	endfunction

	task automatic add_instr(input logic [2:0] o, input logic [11:0] idx,
			input logic [31:0] src, input logic x0);
		instr_q.push_back({o, idx, src, x0});
		items_queued++;
	endtask

	task automatic add_random(input int n);
		for (int i = 0; i < n; i++) begin
			instr_q.push_back(rand_instr());
			items_queued++;
		end
	endtask

	task automatic wait_drained();
		while (results_seen < items_queued)
			@(negedge clk);
	endtask

	task automatic write_id_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_ids(input int kind);
		for (int i = CFG_ISA_WORD; i <= CFG_HART_ID; i++) begin
			if (kind == 0)
				write_id_reg(3'(i), '0);
			else if (kind == 1)
				write_id_reg(3'(i), '1);
			else
				write_id_reg(3'(i), $urandom);
		end
	endtask

	// Word driver: a word is held until it has been accepted.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (instr_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				drv_word = instr_q.pop_front();
				in_valid <= 1'b1;
				op <= drv_word.op;
				csr_index <= drv_word.idx;
				source_value <= drv_word.src;
				source_is_x0 <= drv_word.x0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is asked for.
	always @(negedge clk) begin
		if (holds_done != holds_asked) begin
			holds_done <= holds_asked;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ISA_WORD:  isa_q = cfg_data;
					CFG_VENDOR_ID: vendor_q = cfg_data;
					CFG_ARCH_ID:   arch_q = cfg_data;
					CFG_IMPL_ID:   impl_q = cfg_data;
					CFG_HART_ID:   hart_q = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				seen = {old_value, illegal};
				if (csr_reads_q.size() == 0) begin
					$error("result word with no expectation: old_value %h illegal %b",
						old_value, illegal);
					errors++;
				end else begin
					want = csr_reads_q.pop_front();
					if (seen.old_value !== want.old_value) begin
						$error("old_value: expected %h, got %h", want.old_value,
							seen.old_value);
						errors++;
					end
					if (seen.illegal !== want.illegal) begin
						$error("illegal: expected %b, got %b", want.illegal, seen.illegal);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				csr_reads_q.push_back(exec_csr_instr({op, csr_index, source_value,
					source_is_x0}));
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT)
			@(negedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words, starting from the reset values.
		add_instr(OP_RS,  CSR_ADDR_MISA,      32'h0000_0000, 1'b1);
		add_instr(OP_RW,  CSR_ADDR_MISA,      32'hFFFF_FFFF, 1'b0);
		add_instr(OP_RC,  CSR_ADDR_MVENDORID, 32'hFFFF_FFFF, 1'b0);
		add_instr(OP_RS,  CSR_ADDR_MHARTID,   32'h0000_0000, 1'b1);
		add_instr(OP_RW,  CSR_ADDR_MSTATUS,   32'hFFFF_FFFF, 1'b0);
		add_instr(OP_RW,  CSR_ADDR_MSTATUS,   32'h0000_1000, 1'b0);
		add_instr(OP_RC,  CSR_ADDR_MSTATUS,   32'hFFFF_FFFF, 1'b0);
		add_instr(OP_RS,  CSR_ADDR_MSTATUS,   32'hFFFF_FFFF, 1'b1);
		add_instr(OP_RW,  CSR_ADDR_MTVEC,     32'hFFFF_FFFF, 1'b0);
		add_instr(OP_RW,  CSR_ADDR_MTVEC,     32'h0000_0001, 1'b0);
		add_instr(OP_RW,  CSR_ADDR_MTVEC,     32'hFFFF_FFFE, 1'b0);
		add_instr(OP_RWI, CSR_ADDR_MIP,       32'hFFFF_FFFF, 1'b0);
		add_instr(OP_RSI, CSR_ADDR_MIE,       32'hFFFF_FFE0, 1'b0);
		add_instr(OP_RSI, CSR_ADDR_MIE,       32'h0000_001F, 1'b0);
		add_instr(OP_RCI, CSR_ADDR_MIE,       32'h0000_0000, 1'b0);
		add_instr(OP_RCI, CSR_ADDR_MIE,       32'h0000_0003, 1'b1);
		add_instr(OP_RS,  CSR_ADDR_MCAUSE,    32'h8000_0000, 1'b0);
		add_instr(OP_RW,  CSR_ADDR_MEPC,      32'hFFFF_FFFF, 1'b1);
		add_instr(OP_RC,  CSR_ADDR_MEPC,      32'h0000_FFFF, 1'b0);
		add_instr(OP_RW,  CSR_ADDR_MTVAL,     32'hFFFF_FFFF, 1'b0);
		add_instr(OP_RS,  CSR_ADDR_MTVAL,     32'h0000_0000, 1'b0);
		add_instr(OP_RW,  UNKNOWN_CSR_LO,     32'hFFFF_FFFF, 1'b0);
		add_instr(OP_RS,  UNKNOWN_CSR_HI,     32'hFFFF_FFFF, 1'b0);
		add_instr(OP_UNDEF_LO, CSR_ADDR_MSTATUS, 32'hFFFF_FFFF, 1'b0);
		add_instr(OP_UNDEF_HI, CSR_ADDR_MTVAL,   32'h0000_0000, 1'b0);
		add_random(60);
		wait_drained();

		// The sender gaps, with one pause mid-phase until everything is back.
		program_ids(0);
		tx_idle_pct = 69;
		rx_stall_pct = 0;
		add_random(40);
		wait_drained();
		add_random(40);
		wait_drained();

		program_ids(1);
		tx_idle_pct = 0;
		rx_stall_pct = 69;
		add_random(80);
		wait_drained();

		program_ids(2);
		tx_idle_pct = 36;
		rx_stall_pct = 36;
		add_random(80);
		wait_drained();

		// The receiver holds off while words keep coming, so the block fills.
		program_ids(2);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		add_random(80);
		@(posedge clk);
		holds_asked++;
		wait_drained();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (csr_reads_q.size() != 0) begin
			$error("%0d expected result words never arrived", csr_reads_q.size());
			errors++;
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
